// File: src/iac_pkg.sv
// Shared types and constants for the interval admission counter.
// No dependencies; imported by iac_cell and interval_admission_counter_core.
package iac_pkg;

  // Default configuration of the block
  localparam int unsigned SlotsDef    = 64;
  localparam int unsigned TimeBitsDef = 32;

  // Fixed field widths
  localparam int unsigned FieldTimeW  = 32;
  localparam int unsigned CapW        = 7;
  localparam int unsigned TotalW      = 32;
  localparam int unsigned OccW        = 7;

  // Control part of the sweep word handed from cell to cell
  typedef struct packed {
    logic vld;    // word present at this cell
    logic clr;    // restart: clear slots as the word passes
    logic found;  // a free slot has already been seen upstream
  } sweep_ctl_t;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SWEEP  = 3'b010,
    S_DECIDE = 3'b100
  } iac_state_e;

endpackage

// File: src/interval_admission_counter_core.sv
// Greedy k-server interval admission: sequencer, row of slot cells, counters.
// Depends on iac_pkg and iac_cell.
//
// Usage: intervals enter on the input channel (in_valid_i / in_stall_o) in
// nondecreasing arrival order, one word per interval with arrival, departure
// and restart. Each word yields exactly one result word on the output
// channel (out_valid_o / out_stall_i): the admit decision, the saturating
// admitted count since restart, and the number of busy servers.
// A sweep word walks the row of Slots cells, one cell per cycle; each cell
// frees its slot if its departure is before the arrival, adds its busy bit
// to the running count and marks itself if it is the first free slot. The
// marked cell then takes the interval when it is admitted.
// One interval is in work at a time: the next is accepted only after the
// decision for the last has been loaded, so the throughput is set by the
// length of the cell row.
// The capacity register (cfg_we_i / cfg_wdata_i) is to be written only while
// idle; the block does not enforce this. Values above Slots act as Slots.
// Reset empties all slots, clears the count and capacity. A stalled result
// holds in the output register; the next interval may be accepted meanwhile
// but its decision waits until the held result is taken.
module interval_admission_counter_core import iac_pkg::*; #(
  parameter int unsigned Slots    = SlotsDef,
  parameter int unsigned TimeBits = TimeBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CapW-1:0]       cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FieldTimeW-1:0] arrival_time_i,
  input  logic [FieldTimeW-1:0] departure_time_i,
  input  logic                  restart_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  admitted_o,
  output logic [TotalW-1:0]     admitted_count_o,
  output logic [OccW-1:0]       occupied_o
);

  localparam int unsigned CntW = $clog2(Slots + 1);
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;
  localparam int unsigned OccSumW = (CmpW > OccW) ? CmpW : OccW;

  iac_state_e state_q, state_d;

  logic [CapW-1:0]     cap_q;
  logic [TimeBits-1:0] arr_t, dep_t;
  logic [TimeBits-1:0] arr_q, dep_q;
  logic                clr_q;
  logic                inject_q;
  logic                in_acc;
  logic                fire;
  logic                admit;
  logic [CntW-1:0]     busy_q;
  logic                found_q;
  logic [TotalW-1:0]   total_q, total_d, total_base;
  logic [OccSumW-1:0]  occ_sum;

  logic                out_valid_q;
  logic                admitted_q;
  logic [TotalW-1:0]   count_q;
  logic [OccW-1:0]     occ_q;

  sweep_ctl_t          ctl [Slots+1];
  logic [CntW-1:0]     cnt [Slots+1];

  // Mask or widen the times to the stored width
  if (TimeBits > FieldTimeW) begin : g_wide
    assign arr_t = {{(TimeBits - FieldTimeW){1'b0}}, arrival_time_i};
    assign dep_t = {{(TimeBits - FieldTimeW){1'b0}}, departure_time_i};
  end else if (TimeBits == FieldTimeW) begin : g_same
    assign arr_t = arrival_time_i;
    assign dep_t = departure_time_i;
  end else begin : g_narrow
    assign arr_t = arrival_time_i[TimeBits-1:0];
    assign dep_t = departure_time_i[TimeBits-1:0];
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Admission decision on the swept count
  assign admit = found_q && (CmpW'(busy_q) < CmpW'(cap_q));
  assign fire  = (state_q == S_DECIDE) && (!out_valid_q || !out_stall_i);

  // Sequence: accept, sweep the row, decide
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = S_SWEEP;
      S_SWEEP:  if (ctl[Slots].vld) state_d = S_DECIDE;
      S_DECIDE: if (fire) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Saturating admitted total, cleared by restart
  always_comb begin
    total_base = clr_q ? '0 : total_q;
    total_d    = total_base;
    if (admit && (total_base != '1)) begin
      total_d = total_base + TotalW'(1);
    end
  end

  assign occ_sum = OccSumW'(busy_q) + OccSumW'(admit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= '0;
      inject_q    <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      inject_q <= in_acc;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (fire) begin
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the word under work, capture the sweep tail, load results
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      arr_q <= arr_t;
      dep_q <= dep_t;
      clr_q <= restart_i;
    end
    if (ctl[Slots].vld) begin
      busy_q  <= cnt[Slots];
      found_q <= ctl[Slots].found;
    end
    if (fire) begin
      admitted_q <= admit;
      count_q    <= total_d;
      occ_q      <= occ_sum[OccW-1:0];
    end
  end

  // Head of the row
  assign ctl[0] = '{vld: inject_q, clr: clr_q, found: 1'b0};
  assign cnt[0] = '0;

  // Row of slot cells
  for (genvar i = 0; i < Slots; i++) begin : g_cell
    iac_cell #(
      .TimeBits(TimeBits),
      .CntW    (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .arrival_i  (arr_q),
      .departure_i(dep_q),
      .claim_i    (fire && admit),
      .ctl_i      (ctl[i]),
      .cnt_i      (cnt[i]),
      .ctl_o      (ctl[i+1]),
      .cnt_o      (cnt[i+1])
    );
  end

  assign out_valid_o      = out_valid_q;
  assign admitted_o       = admitted_q;
  assign admitted_count_o = count_q;
  assign occupied_o       = occ_q;

endmodule

// File: src/iac_cell.sv
// One slot of the admission chain: held departure, busy bit, first-free mark.
// Depends on iac_pkg for the sweep control struct.
module iac_cell import iac_pkg::*; #(
  parameter int unsigned TimeBits = TimeBitsDef,
  parameter int unsigned CntW     = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [TimeBits-1:0] arrival_i,
  input  logic [TimeBits-1:0] departure_i,
  input  logic                claim_i,
  input  sweep_ctl_t          ctl_i,
  input  logic [CntW-1:0]     cnt_i,
  output sweep_ctl_t          ctl_o,
  output logic [CntW-1:0]     cnt_o
);

  logic [TimeBits-1:0] dep_q;
  logic                busy_q, busy_d;
  logic                first_q, first_d;
  sweep_ctl_t          ctl_q, ctl_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                busy_eff;

  // Free the slot if restart or its departure lies before the arrival
  assign busy_eff = !ctl_i.clr && busy_q && !(dep_q < arrival_i);

  // Advance the sweep word and update the slot as it passes
  always_comb begin
    busy_d  = busy_q;
    first_d = first_q;
    ctl_d   = ctl_i;
    cnt_d   = cnt_i;
    if (ctl_i.vld) begin
      busy_d      = busy_eff;
      first_d     = !ctl_i.found && !busy_eff;
      ctl_d.found = ctl_i.found || !busy_eff;
      cnt_d       = cnt_i + CntW'(busy_eff);
    end
    if (claim_i && first_q) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      ctl_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      first_q <= first_d;
      ctl_q   <= ctl_d;
    end
  end

  // Payload: count travels with the word, departure loads on a claim
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    if (claim_i && first_q) begin
      dep_q <= departure_i;
    end
  end

  assign ctl_o = ctl_q;
  assign cnt_o = cnt_q;

endmodule
